// File: sv/tangent_frame_orthonormalize_unit_macros.svh
// Assertion macros for the tangent frame orthonormalizer.
// Included by files that check their own pipeline; needs nothing else.
`ifndef TANGENT_FRAME_ORTHONORMALIZE_UNIT_MACROS_SVH
`define TANGENT_FRAME_ORTHONORMALIZE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TFO_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfo check failed");

// Next-cycle implication, checked outside reset.
`define TFO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfo check failed");

`endif

// File: sv/tfo_pkg.sv
// Shared constants, types and the rounding helper of the tangent frame orthonormalizer.
// No dependencies.
package tfo_pkg;
   localparam int IN_WIDTH_DEF = 24;
   localparam int OUT_FRAC_DEF = 14;
   localparam int OUT_WIDTH = 16;
   localparam int UNIT_SHIFT = 30;
   localparam int UNIT_W = 32;
   localparam int NORM_W = 31;
   localparam int SQ_W = 64;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 31;
   localparam int DIVD_W = 63;
   localparam int UNIT_LAT = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
   localparam int RES_W = UNIT_W + 2;
   localparam int CSR_W = 16;
   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(1);
   localparam int WIDE_W = 68;

   typedef logic signed [UNIT_W-1:0] unit_type;
   typedef logic [2:0][UNIT_W-1:0] uvec_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef struct packed {
      logic valid;
      logic zero;
   } unit_stat_type;

   localparam unit_type UNIT_ONE = unit_type'(64'd1 << UNIT_SHIFT);

   // Right shift, rounding half away from zero.
   function automatic wide_type round_shift(wide_type x, int s);
      logic [WIDE_W-1:0] mag;
      logic [WIDE_W-1:0] m;
      mag = x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
      if (s == 0) return x;
      m = (mag + (WIDE_W'(1) << (s - 1))) >> s;
      return x[WIDE_W-1] ? -wide_type'(m) : wide_type'(m);
   endfunction
endpackage

// File: sv/tfo_delay.sv
// Fixed-depth register delay line for sideband data.
// No dependencies.
module tfo_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);
   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      line_ff[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign d_out = line_ff[DEPTH-1];
endmodule

// File: sv/tfo_unitize.sv
// Pipelined vector normalizer: scale, square, square-root stages, then restoring divide.
// Depends on tfo_pkg and tfo_delay.
module tfo_unitize
   import tfo_pkg::*;
#(
   parameter int VW = IN_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2:0][VW-1:0] v_in,
   output uvec_type          u_out,
   output unit_stat_type     stat_out
);
   localparam int PW = (VW > 1) ? $clog2(VW) : 1;
   localparam int EXT_W = VW + UNIT_SHIFT;
   localparam int SB_W = 3 * NORM_W + 4;

   logic [UNIT_LAT-1:0] valid_ff;
   logic [2:0][VW-1:0] mag_in, mag1_ff, mag2_ff;
   logic [VW-1:0] max_in, max1_ff;
   logic [2:0] neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic zero2_ff, zero3_ff, zero4_ff, zero5_ff;
   logic [PW-1:0] pos_in, pos2_ff;
   logic [2:0][NORM_W-1:0] nm_in, nm3_ff, nm4_ff, nm5_ff, nm_d;
   logic [2:0][2*NORM_W-1:0] sqr4_ff;
   logic [SQ_W-1:0] sq5_ff;
   logic [SQ_W-1:0] sx_cur [SQRT_STEPS];
   logic [SQ_W-1:0] sr_cur [SQRT_STEPS];
   logic [SQ_W-1:0] sx_in [SQRT_STEPS];
   logic [SQ_W-1:0] sr_in [SQRT_STEPS];
   logic [SQ_W-1:0] sx_ff [SQRT_STEPS];
   logic [SQ_W-1:0] sr_ff [SQRT_STEPS];
   logic [SB_W-1:0] sb5, sb_d;
   logic [2:0] neg_d;
   logic zero_d;
   logic [UNIT_W-1:0] len;
   logic [2:0][DIVD_W-1:0] dd_in, dd_ff;
   logic [UNIT_W-1:0] len0_ff;
   logic [3:0] nz0_ff, nz_d;
   logic [2:0][DIVD_W-1:0] rem_cur [DIV_STEPS];
   logic [2:0][DIVD_W-1:0] rem_in [DIV_STEPS];
   logic [2:0][DIVD_W-1:0] rem_ff [DIV_STEPS];
   logic [2:0][NORM_W-1:0] quo_cur [DIV_STEPS];
   logic [2:0][NORM_W-1:0] quo_in [DIV_STEPS];
   logic [2:0][NORM_W-1:0] quo_ff [DIV_STEPS];
   logic [UNIT_W-1:0] dl_cur [DIV_STEPS];
   logic [UNIT_W-1:0] dl_ff [DIV_STEPS];
   uvec_type u_in, u_ff;
   logic zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[UNIT_LAT-2:0], in_valid};
      end
   end

   // Magnitudes and the largest one.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = v_in[i][VW-1] ? VW'(-$signed(v_in[i])) : v_in[i];
      end
      max_in = mag_in[0];
      if (mag_in[1] > max_in) max_in = mag_in[1];
      if (mag_in[2] > max_in) max_in = mag_in[2];
   end

   // Leading one of the largest magnitude.
   always_comb begin
      pos_in = '0;
      for (int i = 0; i < VW; i++) begin
         if (max1_ff[i]) pos_in = PW'(i);
      end
   end

   // Bring the leading one to bit 30; right shifts truncate.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nm_in[i] = NORM_W'(((EXT_W'(mag2_ff[i])) << UNIT_SHIFT) >> pos2_ff);
      end
   end

   always_ff @(posedge clock) begin
      mag1_ff <= mag_in;
      max1_ff <= max_in;
      for (int i = 0; i < 3; i++) neg1_ff[i] <= v_in[i][VW-1];
      mag2_ff <= mag1_ff;
      neg2_ff <= neg1_ff;
      pos2_ff <= pos_in;
      zero2_ff <= (max1_ff == '0);
      nm3_ff <= nm_in;
      neg3_ff <= neg2_ff;
      zero3_ff <= zero2_ff;
      for (int i = 0; i < 3; i++) begin
         sqr4_ff[i] <= (2*NORM_W)'(nm3_ff[i]) * (2*NORM_W)'(nm3_ff[i]);
      end
      nm4_ff <= nm3_ff;
      neg4_ff <= neg3_ff;
      zero4_ff <= zero3_ff;
      sq5_ff <= SQ_W'(sqr4_ff[0]) + SQ_W'(sqr4_ff[1]) + SQ_W'(sqr4_ff[2]);
      nm5_ff <= nm4_ff;
      neg5_ff <= neg4_ff;
      zero5_ff <= zero4_ff;
   end

   // Integer square root, one result bit per stage.
   always_comb begin
      sx_cur[0] = sq5_ff;
      sr_cur[0] = '0;
      for (int k = 1; k < SQRT_STEPS; k++) begin
         sx_cur[k] = sx_ff[k-1];
         sr_cur[k] = sr_ff[k-1];
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (sx_cur[k] >= sr_cur[k] + (SQ_W'(1) << (SQ_W - 2 - 2 * k))) begin
            sx_in[k] = sx_cur[k] - (sr_cur[k] + (SQ_W'(1) << (SQ_W - 2 - 2 * k)));
            sr_in[k] = (sr_cur[k] >> 1) + (SQ_W'(1) << (SQ_W - 2 - 2 * k));
         end else begin
            sx_in[k] = sx_cur[k];
            sr_in[k] = sr_cur[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sr_ff <= sr_in;
   end

   assign sb5 = {nm5_ff, neg5_ff, zero5_ff};

   tfo_delay #(.WIDTH(SB_W), .DEPTH(SQRT_STEPS)) u_sqrt_sb (
      .clock (clock),
      .d_in  (sb5),
      .d_out (sb_d)
   );

   assign nm_d = sb_d[SB_W-1:4];
   assign neg_d = sb_d[3:1];
   assign zero_d = sb_d[0];
   assign len = sr_ff[SQRT_STEPS-1][UNIT_W-1:0];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dd_in[c] = (DIVD_W'(nm_d[c]) << UNIT_SHIFT) + DIVD_W'(len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      dd_ff <= dd_in;
      len0_ff <= len;
      nz0_ff <= {neg_d, zero_d};
   end

   // Restoring divide, one quotient bit per stage, high bit first.
   always_comb begin
      rem_cur[0] = dd_ff;
      quo_cur[0] = '0;
      dl_cur[0] = len0_ff;
      for (int j = 1; j < DIV_STEPS; j++) begin
         rem_cur[j] = rem_ff[j-1];
         quo_cur[j] = quo_ff[j-1];
         dl_cur[j] = dl_ff[j-1];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
         for (int c = 0; c < 3; c++) begin
            if (rem_cur[j][c] >= (DIVD_W'(dl_cur[j]) << (DIV_STEPS - 1 - j))) begin
               rem_in[j][c] = rem_cur[j][c] - (DIVD_W'(dl_cur[j]) << (DIV_STEPS - 1 - j));
               quo_in[j][c] = quo_cur[j][c] | (NORM_W'(1) << (DIV_STEPS - 1 - j));
            end else begin
               rem_in[j][c] = rem_cur[j][c];
               quo_in[j][c] = quo_cur[j][c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dl_ff <= dl_cur;
   end

   tfo_delay #(.WIDTH(4), .DEPTH(DIV_STEPS)) u_div_sb (
      .clock (clock),
      .d_in  (nz0_ff),
      .d_out (nz_d)
   );

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         u_in[c] = nz_d[c+1] ? UNIT_W'(-unit_type'(quo_ff[DIV_STEPS-1][c]))
                             : UNIT_W'(unit_type'(quo_ff[DIV_STEPS-1][c]));
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      zero_ff <= nz_d[0];
   end

   assign u_out = u_ff;
   assign stat_out = '{valid: valid_ff[UNIT_LAT-1], zero: zero_ff};
endmodule

// File: sv/tangent_frame_orthonormalize_unit.sv
// Channel  | ports                               | transfer
// ---------+-------------------------------------+-------------------------------
// request  | start, busy, req_*                  | edge with start high, busy low
// result   | rsp_valid, rsp_*                    | every edge rsp_valid is high
// csr      | csr_valid, csr_ready, csr_data      | edge with valid and ready high
// One vertex per cycle while busy is low. A request passes the input register, the two
// normalizers in series, each a 32-stage square root followed by a 31-stage restoring
// divide, the Gram-Schmidt stages and the handedness stages before rsp_valid rises.
// Synchronous reset clears the valid bits and loads the threshold with 1; busy is high
// only while reset is applied and in the cycle after. The result side cannot stall, so the
// pipeline never holds.
// Top level of the tangent frame orthonormalizer; depends on tfo_pkg, tfo_delay,
// tfo_unitize and the assertion macro header.
`include "tangent_frame_orthonormalize_unit_macros.svh"
module tangent_frame_orthonormalize_unit
   import tfo_pkg::*;
#(
   parameter int IN_WIDTH = IN_WIDTH_DEF,
   parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [IN_WIDTH-1:0] req_normal_x,
   input  logic signed [IN_WIDTH-1:0] req_normal_y,
   input  logic signed [IN_WIDTH-1:0] req_normal_z,
   input  logic signed [IN_WIDTH-1:0] req_tangent_x,
   input  logic signed [IN_WIDTH-1:0] req_tangent_y,
   input  logic signed [IN_WIDTH-1:0] req_tangent_z,
   input  logic signed [IN_WIDTH-1:0] req_bitangent_x,
   input  logic signed [IN_WIDTH-1:0] req_bitangent_y,
   input  logic signed [IN_WIDTH-1:0] req_bitangent_z,
   input  logic                       req_has_normal,
   output logic                       rsp_valid,
   output logic signed [OUT_WIDTH-1:0] rsp_unit_tangent_x,
   output logic signed [OUT_WIDTH-1:0] rsp_unit_tangent_y,
   output logic signed [OUT_WIDTH-1:0] rsp_unit_tangent_z,
   output logic                       rsp_handed_negative,
   output logic                       rsp_degenerate,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_W-1:0]           csr_data
);
   localparam int LEN2_W = 2 * IN_WIDTH + 2;
   localparam int OUT_SHIFT = UNIT_SHIFT - OUT_FRAC_BITS;
   localparam int SB_W = 6 * UNIT_W + 2;
   localparam int PROD_W = 2 * UNIT_W;
   localparam int MUL_W = UNIT_W + RES_W;

   logic busy_ff;
   logic accept;
   logic [CSR_W-1:0] thr_ff;

   logic s0_valid_ff, has0_ff;
   logic [2:0][IN_WIDTH-1:0] n0_ff, t0_ff, b0_ff;
   logic [2:0][2*IN_WIDTH-1:0] sqn1_ff, sqt1_ff, sqb1_ff;
   logic has1_ff;
   logic [LEN2_W-1:0] len2n, len2t, len2b;
   logic [2:0] flags2_ff, flags_d;

   uvec_type un, ut, ub;
   unit_stat_type n_stat, t_stat, b_stat;

   uvec_type nu_in, tu_in;
   logic a_valid_ff, belt_a_ff, bok_a_ff;
   uvec_type nu_a_ff, tu_a_ff, bu_a_ff;

   logic [3:0] g_valid_ff;
   logic signed [PROD_W-1:0] p1_ff [3];
   uvec_type nu1_ff, nu2_ff, tu1_ff, tu2_ff, tu3_ff;
   logic signed [RES_W-1:0] d2_ff;
   logic signed [MUL_W-1:0] q3_ff [3];
   logic [2:0][RES_W-1:0] r4_ff;

   logic [SB_W-1:0] sb_a, sb_r;
   uvec_type ur, nu_r, bu_r;
   unit_stat_type r_stat;
   logic belt_r, bok_r;

   logic f1_valid_ff, f1_degen_ff, f1_bok_ff;
   uvec_type f1_nu_ff, f1_tu_ff, f1_bu_ff;
   logic f2_valid_ff, f2_degen_ff, f2_bok_ff;
   logic signed [PROD_W-1:0] cp2_ff [6];
   uvec_type f2_tu_ff, f2_bu_ff;
   logic f3_valid_ff, f3_degen_ff, f3_bok_ff;
   logic signed [RES_W-1:0] c3_ff [3];
   uvec_type f3_tu_ff, f3_bu_ff;
   logic f4_valid_ff, f4_degen_ff, f4_bok_ff;
   logic signed [MUL_W-1:0] h4_ff [3];
   uvec_type f4_tu_ff;
   wide_type hd;
   logic rsp_valid_ff, rsp_neg_ff, rsp_degen_ff;
   logic [2:0][OUT_WIDTH-1:0] rsp_t_ff;
   wide_type o_tmp [3];

   assign accept = start && !busy_ff;
   assign busy = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         thr_ff <= CSR_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) thr_ff <= csr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      n0_ff <= {req_normal_z, req_normal_y, req_normal_x};
      t0_ff <= {req_tangent_z, req_tangent_y, req_tangent_x};
      b0_ff <= {req_bitangent_z, req_bitangent_y, req_bitangent_x};
      has0_ff <= req_has_normal;
   end

   // Raw squared lengths against the threshold, two stages.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sqn1_ff[i] <= (2*IN_WIDTH)'(n0_ff[i][IN_WIDTH-1] ? IN_WIDTH'(-$signed(n0_ff[i]))
                                                          : n0_ff[i])
                       * (2*IN_WIDTH)'(n0_ff[i][IN_WIDTH-1] ? IN_WIDTH'(-$signed(n0_ff[i]))
                                                            : n0_ff[i]);
         sqt1_ff[i] <= (2*IN_WIDTH)'(t0_ff[i][IN_WIDTH-1] ? IN_WIDTH'(-$signed(t0_ff[i]))
                                                          : t0_ff[i])
                       * (2*IN_WIDTH)'(t0_ff[i][IN_WIDTH-1] ? IN_WIDTH'(-$signed(t0_ff[i]))
                                                            : t0_ff[i]);
         sqb1_ff[i] <= (2*IN_WIDTH)'(b0_ff[i][IN_WIDTH-1] ? IN_WIDTH'(-$signed(b0_ff[i]))
                                                          : b0_ff[i])
                       * (2*IN_WIDTH)'(b0_ff[i][IN_WIDTH-1] ? IN_WIDTH'(-$signed(b0_ff[i]))
                                                            : b0_ff[i]);
      end
      has1_ff <= has0_ff;
   end

   assign len2n = LEN2_W'(sqn1_ff[0]) + LEN2_W'(sqn1_ff[1]) + LEN2_W'(sqn1_ff[2]);
   assign len2t = LEN2_W'(sqt1_ff[0]) + LEN2_W'(sqt1_ff[1]) + LEN2_W'(sqt1_ff[2]);
   assign len2b = LEN2_W'(sqb1_ff[0]) + LEN2_W'(sqb1_ff[1]) + LEN2_W'(sqb1_ff[2]);

   // flags: [2] normal replaced, [1] tangent replaced, [0] bitangent usable
   always_ff @(posedge clock) begin
      flags2_ff[2] <= !has1_ff || (len2n == '0) || (len2n < LEN2_W'(thr_ff));
      flags2_ff[1] <= (len2t == '0) || (len2t < LEN2_W'(thr_ff));
      flags2_ff[0] <= (len2b != '0) && (len2b >= LEN2_W'(thr_ff));
   end

   tfo_delay #(.WIDTH(3), .DEPTH(UNIT_LAT - 2)) u_flag_dly (
      .clock (clock),
      .d_in  (flags2_ff),
      .d_out (flags_d)
   );

   tfo_unitize #(.VW(IN_WIDTH)) u_unit_n (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s0_valid_ff),
      .v_in     (n0_ff),
      .u_out    (un),
      .stat_out (n_stat)
   );

   tfo_unitize #(.VW(IN_WIDTH)) u_unit_t (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s0_valid_ff),
      .v_in     (t0_ff),
      .u_out    (ut),
      .stat_out (t_stat)
   );

   tfo_unitize #(.VW(IN_WIDTH)) u_unit_b (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s0_valid_ff),
      .v_in     (b0_ff),
      .u_out    (ub),
      .stat_out (b_stat)
   );

   // Substitute +Z for a short or absent normal and +X for a short tangent.
   assign nu_in = flags_d[2] ? {UNIT_ONE, unit_type'(0), unit_type'(0)} : un;
   assign tu_in = flags_d[1] ? {unit_type'(0), unit_type'(0), UNIT_ONE} : ut;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         g_valid_ff <= '0;
      end else begin
         a_valid_ff <= n_stat.valid;
         g_valid_ff <= {g_valid_ff[2:0], a_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      nu_a_ff <= nu_in;
      tu_a_ff <= tu_in;
      bu_a_ff <= ub;
      belt_a_ff <= flags_d[1];
      bok_a_ff <= flags_d[0];
   end

   // Gram-Schmidt: dot, scale, subtract.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         p1_ff[i] <= $signed(nu_a_ff[i]) * $signed(tu_a_ff[i]);
      end
      nu1_ff <= nu_a_ff;
      tu1_ff <= tu_a_ff;
      d2_ff <= RES_W'(round_shift(wide_type'(p1_ff[0]) + wide_type'(p1_ff[1])
                                  + wide_type'(p1_ff[2]), UNIT_SHIFT));
      nu2_ff <= nu1_ff;
      tu2_ff <= tu1_ff;
      for (int i = 0; i < 3; i++) begin
         q3_ff[i] <= $signed(nu2_ff[i]) * d2_ff;
      end
      tu3_ff <= tu2_ff;
      for (int i = 0; i < 3; i++) begin
         r4_ff[i] <= RES_W'(wide_type'($signed(tu3_ff[i]))
                            - round_shift(wide_type'(q3_ff[i]), UNIT_SHIFT));
      end
   end

   tfo_unitize #(.VW(RES_W)) u_unit_r (
      .clock    (clock),
      .reset    (reset),
      .in_valid (g_valid_ff[3]),
      .v_in     (r4_ff),
      .u_out    (ur),
      .stat_out (r_stat)
   );

   assign sb_a = {nu_a_ff, bu_a_ff, belt_a_ff, bok_a_ff};

   tfo_delay #(.WIDTH(SB_W), .DEPTH(4 + UNIT_LAT)) u_gs_sb (
      .clock (clock),
      .d_in  (sb_a),
      .d_out (sb_r)
   );

   assign nu_r = sb_r[SB_W-1 -: 3*UNIT_W];
   assign bu_r = sb_r[SB_W-1-3*UNIT_W -: 3*UNIT_W];
   assign belt_r = sb_r[1];
   assign bok_r = sb_r[0];

   // Handedness pipeline and output rounding.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= r_stat.valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
         rsp_valid_ff <= f4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      // A short tangent keeps +X; a vanished residual falls back to +X and flags it.
      if (belt_r || r_stat.zero) begin
         f1_tu_ff <= {unit_type'(0), unit_type'(0), UNIT_ONE};
      end else begin
         f1_tu_ff <= ur;
      end
      f1_degen_ff <= !belt_r && r_stat.zero;
      f1_bok_ff <= bok_r && !(!belt_r && r_stat.zero);
      f1_nu_ff <= nu_r;
      f1_bu_ff <= bu_r;

      cp2_ff[0] <= $signed(f1_nu_ff[1]) * $signed(f1_tu_ff[2]);
      cp2_ff[1] <= $signed(f1_nu_ff[2]) * $signed(f1_tu_ff[1]);
      cp2_ff[2] <= $signed(f1_nu_ff[2]) * $signed(f1_tu_ff[0]);
      cp2_ff[3] <= $signed(f1_nu_ff[0]) * $signed(f1_tu_ff[2]);
      cp2_ff[4] <= $signed(f1_nu_ff[0]) * $signed(f1_tu_ff[1]);
      cp2_ff[5] <= $signed(f1_nu_ff[1]) * $signed(f1_tu_ff[0]);
      f2_tu_ff <= f1_tu_ff;
      f2_bu_ff <= f1_bu_ff;
      f2_degen_ff <= f1_degen_ff;
      f2_bok_ff <= f1_bok_ff;

      for (int i = 0; i < 3; i++) begin
         c3_ff[i] <= RES_W'(round_shift(wide_type'(cp2_ff[2*i]) - wide_type'(cp2_ff[2*i+1]),
                                        UNIT_SHIFT));
      end
      f3_tu_ff <= f2_tu_ff;
      f3_bu_ff <= f2_bu_ff;
      f3_degen_ff <= f2_degen_ff;
      f3_bok_ff <= f2_bok_ff;

      for (int i = 0; i < 3; i++) begin
         h4_ff[i] <= c3_ff[i] * $signed(f3_bu_ff[i]);
      end
      f4_tu_ff <= f3_tu_ff;
      f4_degen_ff <= f3_degen_ff;
      f4_bok_ff <= f3_bok_ff;

      rsp_neg_ff <= f4_bok_ff && hd[WIDE_W-1];
      rsp_degen_ff <= f4_degen_ff;
      for (int i = 0; i < 3; i++) begin
         rsp_t_ff[i] <= o_tmp[i][OUT_WIDTH-1:0];
      end
   end

   assign hd = wide_type'(h4_ff[0]) + wide_type'(h4_ff[1]) + wide_type'(h4_ff[2]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_tmp[i] = round_shift(wide_type'($signed(f4_tu_ff[i])), OUT_SHIFT);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_unit_tangent_x = rsp_t_ff[0];
   assign rsp_unit_tangent_y = rsp_t_ff[1];
   assign rsp_unit_tangent_z = rsp_t_ff[2];
   assign rsp_handed_negative = rsp_neg_ff;
   assign rsp_degenerate = rsp_degen_ff;

   `TFO_ASSERT_IMPLY(a_units_aligned, clock, reset, n_stat.valid,
                     t_stat.valid && b_stat.valid)
   `TFO_ASSERT_IMPLY(a_zero_normal_replaced, clock, reset, n_stat.valid && n_stat.zero,
                     flags_d[2])
   `TFO_ASSERT_IMPLY(a_zero_tangent_replaced, clock, reset, t_stat.valid && t_stat.zero,
                     flags_d[1])
   `TFO_ASSERT_IMPLY(a_zero_bitangent_unused, clock, reset, b_stat.valid && b_stat.zero,
                     !flags_d[0])
   `TFO_ASSERT_NEXT(a_degen_drops_handed, clock, reset, f1_valid_ff && f1_degen_ff,
                    !f2_bok_ff)
   `TFO_ASSERT_IMPLY(a_degen_is_plus_x, clock, reset, rsp_valid && rsp_degenerate,
                     !rsp_handed_negative && rsp_unit_tangent_y == '0
                     && rsp_unit_tangent_z == '0)
endmodule
